// ===== sv/ack_retransmit_tracker_core_macros.svh =====
// assertion helpers, clocked on clk_i and disabled in reset
`ifndef ACK_RETRANSMIT_TRACKER_CORE_MACROS_SVH
`define ACK_RETRANSMIT_TRACKER_CORE_MACROS_SVH

// same-cycle implication
`define ART_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ART_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/art_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package art_pkg;

  localparam int unsigned TableDepthDefault = 16;
  localparam int unsigned MaxResults        = 16;
  localparam int unsigned ResCntW           = $clog2(MaxResults + 1);
  localparam int unsigned CfgIdxW           = 3;

  localparam logic [2:0] KIND_ENQ   = 3'd0;
  localparam logic [2:0] KIND_DRAIN = 3'd1;
  localparam logic [2:0] KIND_RESP  = 3'd2;
  localparam logic [2:0] KIND_CONF  = 3'd3;
  localparam logic [2:0] KIND_TICK  = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_TO_FIRST  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TO_SECOND = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TO_LATER  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ATT   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GRACE     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CLEANUP   = 3'd5;

  localparam logic [31:0] RST_TO_FIRST  = 32'd15000;
  localparam logic [31:0] RST_TO_SECOND = 32'd30000;
  localparam logic [31:0] RST_TO_LATER  = 32'd60000;
  localparam logic [2:0]  RST_MAX_ATT   = 3'd3;
  localparam logic [31:0] RST_GRACE     = 32'd30000;
  localparam logic [31:0] RST_CLEANUP   = 32'd120000;

  typedef enum logic [2:0] {
    EVT_SENT      = 3'd0,
    EVT_RETRY     = 3'd1,
    EVT_CONFIRMED = 3'd2,
    EVT_FAILED    = 3'd3,
    EVT_REJECTED  = 3'd4
  } evt_code_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] msg_tag;
    logic [31:0] ack_word;
    logic [31:0] round_trip;
    logic [31:0] now_ms;
    logic        link_ok;
  } in_item_t;

  typedef struct packed {
    logic [15:0] event_tag;
    logic [2:0]  event_code;
    logic [2:0]  attempt_count;
    logic [2:0]  wire_attempt;
    logic [31:0] rtt_out;
    logic        last_event;
  } out_item_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [2:0]  attempts;
    logic [31:0] sent_time;
    logic        armed;
    logic [31:0] exp_ack;
    logic        in_grace;
    logic [31:0] grace_start;
  } ent_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_NEW, WR_SENT, WR_ARM, WR_RETRY, WR_GRACE, WR_SHIFT
  } wr_op_e;

  typedef enum logic [1:0] {ATT_ZERO, ATT_ONE, ATT_ENT, ATT_INC} att_sel_e;

  typedef enum logic [2:0] {IDX_HOLD, IDX_ZERO, IDX_TOP, IDX_INC, IDX_DEC} idx_op_e;

  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_READ, ST_LOAD, ST_EVAL, ST_FAIL2, ST_SH_RD, ST_SH_WR,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic      accept;
    logic      rd_en;
    logic      rd_shift;
    wr_op_e    wr_op;
    logic      load;
    logic      emit;
    evt_code_e emit_code;
    att_sel_e  att_sel;
    logic      flush;
    idx_op_e   idx_op;
    logic      sh_init;
    logic      sh_inc;
    cnt_op_e   cnt_op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       link;
    logic       cnt_zero;
    logic       full;
    logic       idx_last;
    logic       idx_zero;
    logic       sh_more;
    logic       att_zero;
    logic       armed;
    logic       in_grace;
    logic       ack_match;
    logic       grace_exp;
    logic       timed_out;
    logic       clean_exp;
    logic       below_max;
    logic       can_emit;
    logic       flush_ok;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/art_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module art_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/art_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module art_ctrl
  import art_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire dp_stat_t  stat_i,
  output ctrl_cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (stat_i.kind == KIND_DRAIN) begin
          state_d = (stat_i.link && !stat_i.cnt_zero) ? ST_READ : ST_FINISH;
        end else if (stat_i.kind == KIND_RESP || stat_i.kind == KIND_CONF ||
                     stat_i.kind == KIND_TICK) begin
          state_d = stat_i.cnt_zero ? ST_FINISH : ST_READ;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: state_d = ST_EVAL;
      ST_EVAL: begin
        if (stat_i.can_emit) begin
          priority if (stat_i.kind == KIND_DRAIN) begin
            state_d = stat_i.idx_last ? ST_FINISH : ST_READ;
          end else if (stat_i.kind == KIND_RESP) begin
            state_d = (!stat_i.armed || stat_i.idx_zero) ? ST_FINISH : ST_READ;
          end else if (stat_i.kind == KIND_CONF) begin
            if (stat_i.armed && stat_i.ack_match) state_d = ST_SH_RD;
            else state_d = stat_i.idx_zero ? ST_FINISH : ST_READ;
          end else begin
            priority if (!stat_i.att_zero && stat_i.in_grace && stat_i.grace_exp) begin
              state_d = ST_SH_RD;
            end else if (!stat_i.att_zero && !stat_i.in_grace && !stat_i.armed &&
                         stat_i.timed_out && stat_i.below_max && !stat_i.link) begin
              state_d = ST_FAIL2;
            end else if (!stat_i.att_zero && !stat_i.in_grace && stat_i.armed &&
                         stat_i.clean_exp) begin
              state_d = ST_SH_RD;
            end else begin
              state_d = stat_i.idx_zero ? ST_FINISH : ST_READ;
            end
          end
        end
      end
      ST_FAIL2: begin
        if (stat_i.can_emit) state_d = ST_SH_RD;
      end
      ST_SH_RD: begin
        if (stat_i.sh_more) state_d = ST_SH_WR;
        else if (stat_i.kind == KIND_TICK && !stat_i.idx_zero) state_d = ST_READ;
        else state_d = ST_FINISH;
      end
      ST_SH_WR: state_d = ST_SH_RD;
      ST_FINISH: begin
        if (stat_i.flush_ok) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.wr_op     = WR_NONE;
    cmd_o.emit_code = EVT_SENT;
    cmd_o.att_sel   = ATT_ZERO;
    cmd_o.idx_op    = IDX_HOLD;
    cmd_o.cnt_op    = CNT_HOLD;
    unique case (state_q)
      ST_IDLE: cmd_o.accept = in_valid_i;
      ST_DECODE: begin
        priority if (stat_i.kind == KIND_ENQ) begin
          if (stat_i.full) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_code = EVT_REJECTED;
          end else begin
            cmd_o.wr_op  = WR_NEW;
            cmd_o.cnt_op = CNT_INC;
          end
        end else if (stat_i.kind == KIND_DRAIN) begin
          cmd_o.idx_op = IDX_ZERO;
        end else begin
          cmd_o.idx_op = IDX_TOP;
        end
      end
      ST_READ: cmd_o.rd_en = 1'b1;
      ST_LOAD: cmd_o.load = 1'b1;
      ST_EVAL: begin
        if (stat_i.can_emit) begin
          priority if (stat_i.kind == KIND_DRAIN) begin
            if (stat_i.att_zero) begin
              cmd_o.wr_op     = WR_SENT;
              cmd_o.emit      = 1'b1;
              cmd_o.emit_code = EVT_SENT;
              cmd_o.att_sel   = ATT_ONE;
            end
            if (!stat_i.idx_last) cmd_o.idx_op = IDX_INC;
          end else if (stat_i.kind == KIND_RESP) begin
            if (!stat_i.armed) cmd_o.wr_op = WR_ARM;
            else if (!stat_i.idx_zero) cmd_o.idx_op = IDX_DEC;
          end else if (stat_i.kind == KIND_CONF) begin
            if (stat_i.armed && stat_i.ack_match) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_code = EVT_CONFIRMED;
              cmd_o.att_sel   = ATT_ENT;
              cmd_o.sh_init   = 1'b1;
            end else if (!stat_i.idx_zero) begin
              cmd_o.idx_op = IDX_DEC;
            end
          end else begin
            priority if (stat_i.att_zero) begin
              if (!stat_i.idx_zero) cmd_o.idx_op = IDX_DEC;
            end else if (stat_i.in_grace) begin
              if (stat_i.grace_exp) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_code = EVT_FAILED;
                cmd_o.att_sel   = ATT_ENT;
                cmd_o.sh_init   = 1'b1;
              end else if (!stat_i.idx_zero) begin
                cmd_o.idx_op = IDX_DEC;
              end
            end else if (!stat_i.armed && stat_i.timed_out) begin
              if (stat_i.below_max) begin
                cmd_o.wr_op     = WR_RETRY;
                cmd_o.emit      = 1'b1;
                cmd_o.emit_code = EVT_RETRY;
                cmd_o.att_sel   = ATT_INC;
                if (stat_i.link && !stat_i.idx_zero) cmd_o.idx_op = IDX_DEC;
              end else begin
                cmd_o.wr_op = WR_GRACE;
                if (!stat_i.idx_zero) cmd_o.idx_op = IDX_DEC;
              end
            end else if (stat_i.armed && stat_i.clean_exp) begin
              cmd_o.sh_init = 1'b1;
            end else if (!stat_i.idx_zero) begin
              cmd_o.idx_op = IDX_DEC;
            end
          end
        end
      end
      ST_FAIL2: begin
        if (stat_i.can_emit) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_code = EVT_FAILED;
          cmd_o.att_sel   = ATT_ENT;
          cmd_o.sh_init   = 1'b1;
        end
      end
      ST_SH_RD: begin
        if (stat_i.sh_more) begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_shift = 1'b1;
        end else begin
          cmd_o.cnt_op = CNT_DEC;
          if (stat_i.kind == KIND_TICK && !stat_i.idx_zero) cmd_o.idx_op = IDX_DEC;
        end
      end
      ST_SH_WR: begin
        cmd_o.wr_op  = WR_SHIFT;
        cmd_o.sh_inc = 1'b1;
      end
      ST_FINISH: cmd_o.flush = stat_i.flush_ok;
      default: cmd_o.accept = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/art_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "ack_retransmit_tracker_core_macros.svh"

module art_datapath
  import art_pkg::*;
#(
  parameter int unsigned DEPTH = TableDepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire in_item_t           in_item_i,
  input  wire logic               cfg_valid_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire ctrl_cmd_t          cmd_i,
  output dp_stat_t                stat_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_item_t               out_item_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [31:0] to_first_q, to_second_q, to_later_q, grace_q, cleanup_q;
  logic [2:0]  max_att_q;

  in_item_t  item_q;
  ent_t      ent_q, rdata, wdata;
  logic [IdxW-1:0] idx_q, waddr, raddr;
  logic [CntW-1:0] cnt_q, sh_q, sh_nx, idx_nx;
  logic [ResCntW-1:0] res_q;
  logic grace_exp_q, timed_out_q, clean_exp_q, ack_match_q, below_max_q;
  logic [31:0] elapsed, limit;
  out_item_t ev, pend_q, out_q, pend_last;
  logic pend_v_q, out_v_q, out_free, emit_ok, we;
  logic [2:0] ev_att;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      to_first_q  <= RST_TO_FIRST;
      to_second_q <= RST_TO_SECOND;
      to_later_q  <= RST_TO_LATER;
      max_att_q   <= RST_MAX_ATT;
      grace_q     <= RST_GRACE;
      cleanup_q   <= RST_CLEANUP;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TO_FIRST:  to_first_q  <= cfg_data_i;
        CFG_TO_SECOND: to_second_q <= cfg_data_i;
        CFG_TO_LATER:  to_later_q  <= cfg_data_i;
        CFG_MAX_ATT:   max_att_q   <= cfg_data_i[2:0];
        CFG_GRACE:     grace_q     <= cfg_data_i;
        CFG_CLEANUP:   cleanup_q   <= cfg_data_i;
        default:       max_att_q   <= max_att_q;
      endcase
    end
  end

  assign sh_nx  = sh_q + 1'b1;
  assign idx_nx = {{(CntW - IdxW){1'b0}}, idx_q} + 1'b1;
  assign raddr  = cmd_i.rd_shift ? sh_nx[IdxW-1:0] : idx_q;

  always_comb begin
    wdata = ent_q;
    waddr = idx_q;
    we    = 1'b1;
    unique case (cmd_i.wr_op)
      WR_NEW: begin
        wdata     = '0;
        wdata.tag = item_q.msg_tag;
        waddr     = cnt_q[IdxW-1:0];
      end
      WR_SENT: begin
        wdata.attempts  = 3'd1;
        wdata.sent_time = item_q.now_ms;
        wdata.armed     = 1'b0;
      end
      WR_ARM: begin
        wdata.armed   = 1'b1;
        wdata.exp_ack = item_q.ack_word;
      end
      WR_RETRY: begin
        wdata.attempts  = ent_q.attempts + 3'd1;
        wdata.sent_time = item_q.now_ms;
        wdata.armed     = 1'b0;
      end
      WR_GRACE: begin
        wdata.in_grace    = 1'b1;
        wdata.grace_start = item_q.now_ms;
      end
      WR_SHIFT: begin
        wdata = rdata;
        waddr = sh_q[IdxW-1:0];
      end
      default: we = 1'b0;
    endcase
  end

  art_ram #(
    .Width($bits(ent_t)),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // entry checks taken from the read data
  assign elapsed = item_q.now_ms - rdata.sent_time;
  always_comb begin
    priority if (rdata.attempts <= 3'd1) limit = to_first_q;
    else if (rdata.attempts == 3'd2) limit = to_second_q;
    else limit = to_later_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) item_q <= in_item_i;
    if (cmd_i.load) begin
      ent_q       <= rdata;
      timed_out_q <= elapsed > limit;
      clean_exp_q <= elapsed > cleanup_q;
      grace_exp_q <= (item_q.now_ms - rdata.grace_start) > grace_q;
      ack_match_q <= rdata.exp_ack == item_q.ack_word;
      below_max_q <= rdata.attempts < max_att_q;
    end else if (cmd_i.wr_op == WR_RETRY) begin
      ent_q.attempts <= ent_q.attempts + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
      sh_q  <= '0;
    end else begin
      unique case (cmd_i.cnt_op)
        CNT_INC: cnt_q <= cnt_q + 1'b1;
        CNT_DEC: cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
      unique case (cmd_i.idx_op)
        IDX_ZERO: idx_q <= '0;
        IDX_TOP:  idx_q <= IdxW'(cnt_q - 1'b1);
        IDX_INC:  idx_q <= idx_q + 1'b1;
        IDX_DEC:  idx_q <= idx_q - 1'b1;
        default:  idx_q <= idx_q;
      endcase
      if (cmd_i.sh_init) sh_q <= {{(CntW - IdxW){1'b0}}, idx_q};
      else if (cmd_i.sh_inc) sh_q <= sh_nx;
    end
  end

  // event build
  always_comb begin
    unique case (cmd_i.att_sel)
      ATT_ZERO: ev_att = 3'd0;
      ATT_ONE:  ev_att = 3'd1;
      ATT_ENT:  ev_att = ent_q.attempts;
      default:  ev_att = ent_q.attempts + 3'd1;
    endcase
    ev.event_tag     = (cmd_i.emit_code == EVT_REJECTED) ? item_q.msg_tag : ent_q.tag;
    ev.event_code    = cmd_i.emit_code;
    ev.attempt_count = ev_att;
    ev.wire_attempt  = (ev_att > 3'd1) ? ev_att - 3'd1 : 3'd0;
    ev.rtt_out       = (cmd_i.emit_code == EVT_CONFIRMED) ? item_q.round_trip : 32'd0;
    ev.last_event    = 1'b0;
  end

  always_comb begin
    pend_last            = pend_q;
    pend_last.last_event = 1'b1;
  end

  assign out_free = !out_v_q || !out_stall_i;
  assign emit_ok  = cmd_i.emit && (res_q < ResCntW'(MaxResults));

  // held result goes out when the next one arrives or the item ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      res_q    <= '0;
    end else begin
      if (cmd_i.accept) res_q <= '0;
      else if (emit_ok) res_q <= res_q + 1'b1;
      if (emit_ok) begin
        pend_v_q <= 1'b1;
        if (pend_v_q) out_v_q <= 1'b1;
        else if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      end else if (cmd_i.flush && pend_v_q) begin
        pend_v_q <= 1'b0;
        out_v_q  <= 1'b1;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ok) begin
      pend_q <= ev;
      if (pend_v_q) out_q <= pend_q;
    end else if (cmd_i.flush && pend_v_q) begin
      out_q <= pend_last;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  always_comb begin
    stat_o.kind      = item_q.kind;
    stat_o.link      = item_q.link_ok;
    stat_o.cnt_zero  = (cnt_q == '0);
    stat_o.full      = (cnt_q == CntW'(DEPTH));
    stat_o.idx_last  = (idx_nx == cnt_q);
    stat_o.idx_zero  = (idx_q == '0);
    stat_o.sh_more   = (sh_nx < cnt_q);
    stat_o.att_zero  = (ent_q.attempts == 3'd0);
    stat_o.armed     = ent_q.armed;
    stat_o.in_grace  = ent_q.in_grace;
    stat_o.ack_match = ack_match_q;
    stat_o.grace_exp = grace_exp_q;
    stat_o.timed_out = timed_out_q;
    stat_o.clean_exp = clean_exp_q;
    stat_o.below_max = below_max_q;
    stat_o.can_emit  = !pend_v_q || out_free;
    stat_o.flush_ok  = !pend_v_q || out_free;
  end

  `ART_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CntW'(DEPTH), "entry count above table depth")
  `ART_ASSERT_NOW(a_emit_room, emit_ok, !pend_v_q || out_free, "result lost on full output")
  `ART_ASSERT_NOW(a_dec_nonzero, cmd_i.cnt_op == CNT_DEC, cnt_q != '0, "removal from empty table")
  `ART_ASSERT_NXT(a_flush_out, cmd_i.flush && pend_v_q, out_v_q && out_q.last_event, "final result missing")

endmodule

`default_nettype wire

// ===== sv/ack_retransmit_tracker_core.sv =====
// Retransmit tracker: an ordered table of pending messages (oldest first, gaps
// closed on removal) kept in a RAM with one read port, one write port and
// registered read. Each input item is accepted only when the block is idle.
// Enqueue, and any item on an empty table, goes without a walk. Drain,
// response-sent, confirm and tick walk the table one entry at a time, reading,
// loading and evaluating each entry visited; removing an entry reads and
// rewrites each younger entry one place down. These steps follow from the RAM
// registered read and its single write port. A walk stalls while the output
// register is still held by the far side. At most 16 results are reported per
// item, the last one marked with last_event. Reset clears the entry count, not
// the table RAM; no clearing pass runs. Configuration writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

module ack_retransmit_tracker_core
  import art_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire in_item_t           in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_item_t               out_item_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  art_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  art_datapath #(
    .DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

// ===== dv/tb_ack_retransmit_tracker_core.sv =====
`timescale 1ns / 1ps

module tb_ack_retransmit_tracker_core;
  import art_pkg::*;

  localparam int unsigned Depth      = 16;
  localparam int unsigned SettleWait = 1500;
  localparam int unsigned IdleLimit  = 30000;

  typedef struct {
    logic [15:0] tag;
    logic [2:0]  attempts;
    logic [31:0] sent_at;
    logic        armed;
    logic [31:0] want_ack;
    logic        in_grace;
    logic [31:0] grace_from;
  } pending_msg_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item = '0;
  logic                out_valid_o;
  logic                out_stall = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [31:0]         cfg_data = '0;

  ack_retransmit_tracker_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  // tracker mirror
  pending_msg_t msgs[Depth];
  int unsigned  msg_count = 0;
  logic [31:0]  to_first = RST_TO_FIRST, to_second = RST_TO_SECOND;
  logic [31:0]  to_later = RST_TO_LATER, grace_ms = RST_GRACE;
  logic [31:0]  cleanup_ms = RST_CLEANUP;
  logic [2:0]   att_limit = RST_MAX_ATT;

  in_item_t  pending_items[$];
  out_item_t expected_events[$];
  int unsigned items_sent = 0, events_seen = 0, cfg_writes = 0;
  int unsigned mismatches = 0, idle_cycles = 0;
  int unsigned burst_left = 0, gap_left = 0, stall_mode = 0;
  logic [31:0] now_t = 0;
  logic [31:0] ack_pool[4];

  function automatic void drop_msg(int unsigned i);
    for (int unsigned k = i; k + 1 < msg_count; k++) msgs[k] = msgs[k + 1];
    msg_count--;
  endfunction

  function automatic void note_event(ref out_item_t evs[$], input logic [15:0] tag,
                                     input evt_code_e code, input logic [2:0] att,
                                     input logic [31:0] rtt);
    out_item_t ev;
    if (evs.size() >= MaxResults) return;
    ev = '0;
    ev.event_tag = tag;
    ev.event_code = code;
    ev.attempt_count = att;
    ev.wire_attempt = (att > 1) ? att - 3'd1 : 3'd0;
    ev.rtt_out = rtt;
    evs.push_back(ev);
  endfunction

  function automatic void track_item(in_item_t it);
    out_item_t evs[$];
    logic [31:0] elapsed, limit;
    int i;
    case (it.kind)
      KIND_ENQ: begin
        if (msg_count >= Depth) begin
          note_event(evs, it.msg_tag, EVT_REJECTED, 3'd0, 32'd0);
        end else begin
          msgs[msg_count] = '{it.msg_tag, 3'd0, 32'd0, 1'b0, 32'd0, 1'b0, 32'd0};
          msg_count++;
        end
      end
      KIND_DRAIN: begin
        if (it.link_ok) begin
          for (i = 0; i < msg_count; i++) begin
            if (msgs[i].attempts == 0) begin
              msgs[i].attempts = 3'd1;
              msgs[i].sent_at = it.now_ms;
              msgs[i].armed = 1'b0;
              note_event(evs, msgs[i].tag, EVT_SENT, 3'd1, 32'd0);
            end
          end
        end
      end
      KIND_RESP: begin
        for (i = int'(msg_count) - 1; i >= 0; i--) begin
          if (!msgs[i].armed) begin
            msgs[i].armed = 1'b1;
            msgs[i].want_ack = it.ack_word;
            break;
          end
        end
      end
      KIND_CONF: begin
        for (i = int'(msg_count) - 1; i >= 0; i--) begin
          if (msgs[i].armed && msgs[i].want_ack == it.ack_word) begin
            note_event(evs, msgs[i].tag, EVT_CONFIRMED, msgs[i].attempts, it.round_trip);
            drop_msg(i);
            break;
          end
        end
      end
      KIND_TICK: begin
        for (i = int'(msg_count) - 1; i >= 0; i--) begin
          if (msgs[i].attempts == 0) continue;
          elapsed = it.now_ms - msgs[i].sent_at;
          limit = (msgs[i].attempts <= 1) ? to_first :
                  (msgs[i].attempts == 2) ? to_second : to_later;
          if (msgs[i].in_grace) begin
            if (it.now_ms - msgs[i].grace_from > grace_ms) begin
              note_event(evs, msgs[i].tag, EVT_FAILED, msgs[i].attempts, 32'd0);
              drop_msg(i);
            end
          end else if (!msgs[i].armed && elapsed > limit) begin
            if (msgs[i].attempts < att_limit) begin
              msgs[i].attempts++;
              msgs[i].sent_at = it.now_ms;
              note_event(evs, msgs[i].tag, EVT_RETRY, msgs[i].attempts, 32'd0);
              if (!it.link_ok) begin
                note_event(evs, msgs[i].tag, EVT_FAILED, msgs[i].attempts, 32'd0);
                drop_msg(i);
              end
            end else begin
              msgs[i].in_grace = 1'b1;
              msgs[i].grace_from = it.now_ms;
            end
          end else if (msgs[i].armed && elapsed > cleanup_ms) begin
            drop_msg(i);
          end
        end
      end
      default: ;
    endcase
    if (evs.size() > 0) evs[evs.size() - 1].last_event = 1'b1;
    foreach (evs[k]) expected_events.push_back(evs[k]);
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        track_item(in_item);
        items_sent++;
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        events_seen++;
        if (expected_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected event: %p", out_item_o);
        end else begin
          automatic out_item_t want = expected_events.pop_front();
          if (out_item_o.event_tag !== want.event_tag ||
              out_item_o.event_code !== want.event_code ||
              out_item_o.attempt_count !== want.attempt_count ||
              out_item_o.wire_attempt !== want.wire_attempt ||
              out_item_o.rtt_out !== want.rtt_out ||
              out_item_o.last_event !== want.last_event) begin
            mismatches++;
            if (mismatches <= 10) $display("event mismatch: expected %p, got %p", want, out_item_o);
          end
        end
      end
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_writes++;
    case (idx)
      CFG_TO_FIRST:  to_first = val;
      CFG_TO_SECOND: to_second = val;
      CFG_TO_LATER:  to_later = val;
      CFG_MAX_ATT:   att_limit = val[2:0];
      CFG_GRACE:     grace_ms = val;
      CFG_CLEANUP:   cleanup_ms = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [31:0] t1, logic [31:0] t2, logic [31:0] t3,
                          logic [2:0] ma, logic [31:0] gr, logic [31:0] cl);
    @(posedge clk_i);
    write_reg(CFG_TO_FIRST, t1);
    write_reg(CFG_TO_SECOND, t2);
    write_reg(CFG_TO_LATER, t3);
    write_reg(CFG_MAX_ATT, {29'd0, ma});
    write_reg(CFG_GRACE, gr);
    write_reg(CFG_CLEANUP, cl);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_settled();
    while (pending_items.size() > 0 || in_valid || expected_events.size() > 0)
      @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  function automatic void add_item(logic [2:0] kind, logic [15:0] tag, logic [31:0] ack,
                                   logic [31:0] rtt, logic [31:0] now, logic link);
    in_item_t it;
    it.kind = kind;
    it.msg_tag = tag;
    it.ack_word = ack;
    it.round_trip = rtt;
    it.now_ms = now;
    it.link_ok = link;
    pending_items.push_back(it);
  endfunction

  task automatic add_random(int unsigned count, int unsigned span);
    int unsigned pick;
    logic [2:0] kind;
    logic [31:0] ack;
    foreach (ack_pool[k]) ack_pool[k] = $urandom;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      kind = (pick < 25) ? KIND_ENQ : (pick < 40) ? KIND_DRAIN : (pick < 55) ? KIND_RESP :
             (pick < 70) ? KIND_CONF : (pick < 96) ? KIND_TICK : 3'($urandom_range(5, 7));
      ack = ($urandom_range(0, 9) == 0) ? $urandom : ack_pool[$urandom_range(0, 3)];
      now_t += $urandom_range(0, span);
      add_item(kind, 16'($urandom), ack, $urandom, now_t, $urandom_range(0, 7) != 0);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults from reset: fill past full, drain, arm, confirm, overflowing tick
    for (int unsigned n = 0; n < 17; n++)
      add_item(KIND_ENQ, (n == 0) ? 16'h0000 : (n == 1) ? 16'hffff : 16'($urandom),
               32'd0, 32'd0, 32'd0, 1'b1);
    add_item(KIND_DRAIN, 16'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    add_item(KIND_TICK, 16'd0, 32'd0, 32'd0, 32'hffffffff, 1'b1);
    add_item(KIND_DRAIN, 16'd0, 32'd0, 32'd0, 32'd0, 1'b1);
    add_item(KIND_RESP, 16'd0, 32'hffffffff, 32'd0, 32'd10, 1'b1);
    add_item(KIND_CONF, 16'd0, 32'h12345678, 32'd5, 32'd20, 1'b1);
    add_item(KIND_CONF, 16'd0, 32'hffffffff, 32'hffffffff, 32'd30, 1'b1);
    add_item(KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd20000, 1'b0);
    add_item(3'd7, 16'hffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1);
    wait_settled();

    set_regs(32'd1, 32'd1, 32'd1, 3'd7, 32'd0, 32'd0);
    now_t = 32'hffffff00;
    add_random(60, 4);
    wait_settled();

    set_regs(32'hffffffff, 32'hffffffff, 32'hffffffff, 3'd1, 32'hffffffff, 32'hffffffff);
    add_random(40, 1000);
    wait_settled();

    for (int unsigned p = 0; p < 4; p++) begin
      set_regs($urandom_range(1, 60), $urandom_range(1, 120), $urandom_range(1, 200),
               3'($urandom_range(1, 7)), $urandom_range(0, 100), $urandom_range(0, 400));
      add_random(52, 60);
      wait_settled();
    end

    $display("run covered %0d items, %0d events and %0d register writes",
             items_sent, events_seen, cfg_writes);
    $display("mismatches: %0d, events still awaited: %0d", mismatches,
             expected_events.size());
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
